/* hdl/lfp_pkg.sv */
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants for the lidar frame parser: item structs, the
// command passed from the byte parser to the table stage, and packet layout.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int ANGLE_COUNT_DEF = 360;
  localparam int CMD_Q_DEPTH     = 4;
  localparam int OUT_Q_DEPTH     = 4;

  // Operation codes of an input item.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Kinds of a result item.
  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  // Packet layout. Byte position zero means hunting for the start byte.
  localparam logic [7:0] START_BYTE      = 8'hFA;
  localparam logic [7:0] INDEX_BASE      = 8'hA0;
  localparam logic [4:0] POS_HUNT        = 5'd0;
  localparam logic [4:0] BODY_LEN        = 5'd21;
  localparam logic [4:0] BODY_INDEX      = 5'd0;
  localparam logic [4:0] BODY_SPEED_LO   = 5'd1;
  localparam logic [4:0] BODY_SPEED_HI   = 5'd2;
  localparam logic [4:0] BODY_READ_FIRST = 5'd3;
  localparam logic [4:0] BODY_READ_LAST  = 5'd18;
  localparam logic [1:0] READ_BYTE_LAST  = 2'd3;

  localparam int RANGE_W  = 14;
  localparam int ANGLE_W  = 9;

  typedef struct packed {
    logic               op;
    logic [7:0]         rx_byte;
    logic [ANGLE_W-1:0] query_angle;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] angle;
    logic [RANGE_W-1:0] range_value;
    logic [15:0]        signal_level;
    logic               bad_flag;
    logic               weak_flag;
    logic [15:0]        spin_rate;
  } out_item_t;

  // The result as far as the parser knows it, plus whether the angle lies
  // inside the table.
  typedef struct packed {
    out_item_t res;
    logic      hit;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

/* hdl/lfp_fifo.sv */
// ----------------------------------------------------------------------------
// lfp_fifo
// Small register queue with a fill level; the head entry is shown while the
// queue is not empty.
// ----------------------------------------------------------------------------
module lfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_push, do_pop;

  assign full    = (level_r == LW'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hdl/lfp_ram.sv */
// ----------------------------------------------------------------------------
// lfp_ram
// Generic memory with one write port and one read port; read data is
// registered.
// ----------------------------------------------------------------------------
module lfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* hdl/lfp_front.sv */
// ----------------------------------------------------------------------------
// lfp_front
// Byte parser: hunts for the start byte, collects the packet body and turns
// each finished reading, and each table query, into a command.
// ----------------------------------------------------------------------------
module lfp_front #(
  parameter int ANGLE_COUNT = lfp_pkg::ANGLE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  lfp_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output lfp_pkg::cmd_t     cmd
);

  import lfp_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [23:0] rd_bytes_r, rd_bytes_nxt;

  logic [4:0]         body_num;
  logic [4:0]         read_off;
  logic [7:0]         index_off;
  logic [7:0]         b1;
  logic [ANGLE_W-1:0] read_angle;
  logic [7:0]         rx;

  assign rx         = in_item.rx_byte;
  assign body_num   = pos_r - 5'd1;
  assign read_off   = body_num - BODY_READ_FIRST;
  assign index_off  = index_r - INDEX_BASE;
  assign b1         = rd_bytes_r[15:8];
  // Four readings per packet, so the angle is the index offset times four
  // plus the slot number.
  assign read_angle = {index_off[6:0], read_off[3:2]};

  always_comb begin
    pos_nxt      = pos_r;
    index_nxt    = index_r;
    speed_nxt    = speed_r;
    rd_bytes_nxt = rd_bytes_r;
    cmd_valid    = 1'b0;
    cmd          = '0;

    if (accept) begin
      if (in_item.op == OP_QUERY) begin
        cmd_valid             = 1'b1;
        cmd.res.kind          = KIND_ANSWER;
        cmd.res.angle         = in_item.query_angle;
        cmd.hit               = (int'(in_item.query_angle) < ANGLE_COUNT);
      end else if (pos_r == POS_HUNT) begin
        if (rx == START_BYTE) begin
          pos_nxt = 5'd1;
        end
      end else begin
        if (body_num == BODY_INDEX) begin
          index_nxt = rx;
        end else if (body_num == BODY_SPEED_LO) begin
          speed_nxt[7:0] = rx;
        end else if (body_num == BODY_SPEED_HI) begin
          speed_nxt[15:8] = rx;
        end else if (body_num >= BODY_READ_FIRST && body_num <= BODY_READ_LAST) begin
          if (read_off[1:0] != READ_BYTE_LAST) begin
            rd_bytes_nxt[8*read_off[1:0] +: 8] = rx;
          end else if (index_r >= INDEX_BASE && int'(read_angle) < ANGLE_COUNT) begin
            cmd_valid            = 1'b1;
            cmd.res.kind         = KIND_READING;
            cmd.res.angle        = read_angle;
            cmd.res.range_value  = {b1[5:0], rd_bytes_r[7:0]};
            cmd.res.signal_level = {rx, rd_bytes_r[23:16]};
            cmd.res.bad_flag     = b1[7];
            cmd.res.weak_flag    = b1[6];
            cmd.res.spin_rate    = speed_r;
            cmd.hit              = 1'b1;
          end
        end
        // The two checksum bytes only advance the position.
        pos_nxt = (pos_r == BODY_LEN) ? POS_HUNT : pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_HUNT;
      index_r    <= '0;
      speed_r    <= '0;
      rd_bytes_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      index_r    <= index_nxt;
      speed_r    <= speed_nxt;
      rd_bytes_r <= rd_bytes_nxt;
    end
  end

endmodule

/* hdl/lfp_back.sv */
// ----------------------------------------------------------------------------
// lfp_back
// Table stage: clears the distance table after reset, stores valid readings,
// answers queries and hands finished results to the output queue.
// ----------------------------------------------------------------------------
module lfp_back #(
  parameter int ANGLE_COUNT = lfp_pkg::ANGLE_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_empty,
  input  lfp_pkg::cmd_t                          cmd,
  output logic                                   cmd_pop,
  input  logic [$clog2(lfp_pkg::OUT_Q_DEPTH+1)-1:0] out_level,
  output logic                                   res_push,
  output lfp_pkg::out_item_t                     res,
  output lfp_pkg::back_stat_t                    stat
);

  import lfp_pkg::*;

  localparam int AW = $clog2(ANGLE_COUNT);

  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          s1_valid_r;
  cmd_t          s1_cmd_r;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [RANGE_W-1:0] ram_wdata;
  logic [RANGE_W-1:0] ram_rdata;

  assign stat.clearing = clr_active_r;

  // A command leaves the queue only when the output queue has room for it
  // and for the result still in flight.
  assign cmd_pop = !cmd_empty && !clr_active_r
                   && ((int'(out_level) + int'(s1_valid_r)) < OUT_Q_DEPTH);

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(cmd.res.angle);
    ram_wdata      = cmd.res.range_value;
    ram_re         = 1'b0;
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
      if (clr_addr_r == AW'(ANGLE_COUNT - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end else if (cmd_pop && cmd.hit) begin
      if (cmd.res.kind == KIND_ANSWER) begin
        ram_re = 1'b1;
      end else if (!cmd.res.bad_flag) begin
        ram_we = 1'b1;
      end
    end
  end

  lfp_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (ANGLE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(cmd.res.angle)),
    .rdata (ram_rdata)
  );

  always_comb begin
    res_push = s1_valid_r;
    res      = s1_cmd_r.res;
    if (s1_cmd_r.res.kind == KIND_ANSWER) begin
      res.range_value = s1_cmd_r.hit ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_valid_r   <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd_r <= cmd;
    end
  end

endmodule

/* hdl/lidar_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// lidar_frame_parser_top
// Lidar serial packet parser with a per-angle distance table.
// ----------------------------------------------------------------------------
// The block takes one item per clock while full is low: a received lidar byte
// or a query of the distance table. A reading passes through the command queue
// and the table stage register into the output queue, and a query answer takes
// the same path, its range coming from the registered read of the table memory.
// Right after reset the block clears the table, one entry per cycle, so full
// stays high, and no item can be transferred, until every entry is cleared.
// Short queues sit between the parser and the table stage and in front of
// the result port, so a stall on either side stops the other only once they fill.
// ----------------------------------------------------------------------------
module lidar_frame_parser_top #(
  parameter int ANGLE_COUNT = lfp_pkg::ANGLE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  lfp_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output lfp_pkg::out_item_t out_item
);

  import lfp_pkg::*;

  localparam int CLW = $clog2(CMD_Q_DEPTH + 1);
  localparam int OLW = $clog2(OUT_Q_DEPTH + 1);

  logic       accept;
  logic       cmd_valid;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       cmdq_full, cmdq_empty, cmd_pop;
  logic [CLW-1:0] cmdq_level;
  logic       outq_full;
  logic [OLW-1:0] outq_level;
  logic       res_push;
  out_item_t  res;
  back_stat_t stat;

  assign full   = cmdq_full || stat.clearing;
  assign accept = push && !full;

  lfp_front #(
    .ANGLE_COUNT (ANGLE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (front_cmd)
  );

  lfp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_valid),
    .wdata (front_cmd),
    .full  (cmdq_full),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .empty (cmdq_empty),
    .level (cmdq_level)
  );

  lfp_back #(
    .ANGLE_COUNT (ANGLE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_level (outq_level),
    .res_push  (res_push),
    .res       (res),
    .stat      (stat)
  );

  // The table stage reserves room before it starts a command, so the output
  // queue is never pushed while full; its full flag only joins the level.
  lfp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push && !outq_full),
    .wdata (res),
    .full  (outq_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty),
    .level (outq_level)
  );

  // The command queue level is kept for debug visibility of parser backlog.
  logic unused_level;
  assign unused_level = ^cmdq_level;

endmodule

/* test/lidar_frame_parser_checker.sv */
// ----------------------------------------------------------------------------
// lidar_frame_parser_checker
// Watches both queue ports of the lidar frame parser, runs its own parser and
// distance table on every accepted input transfer, and compares each result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module lidar_frame_parser_checker #(
  parameter int ANGLE_COUNT = lfp_pkg::ANGLE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  lfp_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  lfp_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfp_pkg::*;

  logic [4:0]         frame_pos;
  logic [7:0]         frame_index;
  logic [15:0]        frame_speed;
  logic [23:0]        reading_lo;
  logic [RANGE_W-1:0] stored_range [ANGLE_COUNT];
  out_item_t          expected_results [$];
  int                 errors = 0;

  // Advances the parser by one input item; returns 1 when the item yields a
  // result, which is then left in res.
  function automatic bit parse_item(input in_item_t it, output out_item_t res);
    logic [4:0] body;
    logic [4:0] rel;
    int         ang;
    bit         found;
    found = 1'b0;
    res = '0;
    if (it.op == OP_QUERY) begin
      res.kind = KIND_ANSWER;
      res.angle = it.query_angle;
      if (it.query_angle < ANGLE_COUNT) res.range_value = stored_range[it.query_angle];
      found = 1'b1;
    end else if (frame_pos == POS_HUNT) begin
      if (it.rx_byte == START_BYTE) frame_pos = 5'd1;
    end else begin
      body = frame_pos - 5'd1;
      rel = body - BODY_READ_FIRST;
      if (body == BODY_INDEX) begin
        frame_index = it.rx_byte;
      end else if (body == BODY_SPEED_LO) begin
        frame_speed[7:0] = it.rx_byte;
      end else if (body == BODY_SPEED_HI) begin
        frame_speed[15:8] = it.rx_byte;
      end else if (body >= BODY_READ_FIRST && body <= BODY_READ_LAST) begin
        if (rel[1:0] != READ_BYTE_LAST) begin
          reading_lo[8*rel[1:0] +: 8] = it.rx_byte;
        end else if (frame_index >= INDEX_BASE) begin
          ang = 4 * (int'(frame_index) - int'(INDEX_BASE)) + int'(rel[4:2]);
          if (ang < ANGLE_COUNT) begin
            res.kind = KIND_READING;
            res.angle = ang[ANGLE_W-1:0];
            res.range_value = {reading_lo[13:8], reading_lo[7:0]};
            res.signal_level = {it.rx_byte, reading_lo[23:16]};
            res.bad_flag = reading_lo[15];
            res.weak_flag = reading_lo[14];
            res.spin_rate = frame_speed;
            // Readings flagged invalid are reported but never stored.
            if (!res.bad_flag) stored_range[ang] = res.range_value;
            found = 1'b1;
          end
        end
      end
      frame_pos = (frame_pos == BODY_LEN) ? POS_HUNT : frame_pos + 5'd1;
    end
    return found;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t res;
    if (!rst_n) begin
      frame_pos = POS_HUNT;
      frame_index = '0;
      frame_speed = '0;
      reading_lo = '0;
      foreach (stored_range[a]) stored_range[a] = '0;
      expected_results.delete();
    end else begin
      // A result transfer never belongs to an item accepted at the same edge,
      // so the result side is checked first.
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual 0x%0h", $time, out_item);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("angle", want.angle, out_item.angle);
          check_field("range_value", want.range_value, out_item.range_value);
          check_field("signal_level", want.signal_level, out_item.signal_level);
          check_field("bad_flag", want.bad_flag, out_item.bad_flag);
          check_field("weak_flag", want.weak_flag, out_item.weak_flag);
          check_field("spin_rate", want.spin_rate, out_item.spin_rate);
        end
      end
      if (push && !full) begin
        if (parse_item(in_item, res)) expected_results.push_back(res);
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
  end

endmodule

/* test/lidar_frame_parser_top_test.sv */
// ----------------------------------------------------------------------------
// lidar_frame_parser_top_test
// Drives the lidar frame parser with a short directed packet, then with random
// packets, truncated packets, line noise and table queries, under bursty input
// and a stalling receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lidar_frame_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TARGET_ITEMS = 650;
  localparam int PAUSE_EVERY  = 200;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  rx_mode_t   rx_mode = RX_STREAM;
  int         rx_left = 0;
  int         burst_left = 0;
  int         item_count = 0;
  int         idle_cycles = 0;
  logic [7:0] frame_body [21];

  lidar_frame_parser_top i_dut (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item
  );

  lidar_frame_parser_checker i_checker (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switches between streaming, coin-flip, sparse and held-off modes.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: pop <= 1'b1;
      RX_COIN:   pop <= 1'($urandom_range(0, 1));
      RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
      default:   pop <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one item and returns once it has been transferred. Items come in
  // bursts separated by random gaps.
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.op = OP_BYTE;
    it.rx_byte = b;
    it.query_angle = ANGLE_W'($urandom_range(0, 511));
    send(it);
  endtask

  task automatic send_query(input int unsigned angle);
    in_item_t it;
    it.op = OP_QUERY;
    it.rx_byte = 8'($urandom);
    it.query_angle = angle[ANGLE_W-1:0];
    send(it);
    item_count++;
  endtask

  // Mostly angles inside the table, sometimes beyond it.
  function automatic int unsigned pick_angle();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
  endfunction

  // Start byte followed by the first n body bytes; queries may slip in between.
  task automatic send_frame(input int n, input bit mix_queries);
    send_byte(START_BYTE);
    item_count++;
    for (int i = 0; i < n; i++) begin
      if (mix_queries && $urandom_range(0, 9) == 0) send_query(pick_angle());
      send_byte(frame_body[i]);
      item_count++;
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int choice;
    int next_pause;
    next_pause = PAUSE_EVERY;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Highest valid index: a full-scale reading with the weak flag, an invalid
    // reading, start bytes inside the body and a reading with both flags set.
    send_query(0);
    frame_body = '{8'hF9, 8'hFF, 8'hFF,
                   8'hFF, 8'h7F, 8'hFF, 8'hFF,
                   8'h12, 8'h85, 8'h00, 8'h00,
                   8'hFA, 8'h00, 8'hFA, 8'h00,
                   8'h00, 8'hC0, 8'h00, 8'h00,
                   8'hFA, 8'h00};
    send_frame(21, 1'b1);
    send_query(356);
    send_query(357);
    send_query(511);
    wait_drained();

    while (item_count < TARGET_ITEMS) begin
      choice = $urandom_range(0, 19);
      if (choice < 13) begin
        // Indexes below 0xA0 or from 0xFA up produce no readings.
        if ($urandom_range(0, 7) == 0) begin
          frame_body[0] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h9F))
                                               : 8'($urandom_range(8'hFA, 8'hFF));
        end else begin
          frame_body[0] = 8'($urandom_range(INDEX_BASE, 8'hF9));
        end
        for (int i = 1; i < 21; i++) frame_body[i] = 8'($urandom);
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : 21, 1'b1);
      end else if (choice < 16) begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(8'($urandom));
          item_count++;
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_query(pick_angle());
      end
      if (item_count >= next_pause) begin
        wait_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
